### sv/bksu_pkg.sv
// ----------------------------------------------------------------------------
// bksu_pkg
// Types and constants for the barometric Kalman scalar update core.
// ----------------------------------------------------------------------------
package bksu_pkg;

  localparam int STATE_SIZE_DEF = 10;
  localparam int Z_POSITION_DEF = 2;

  localparam logic [1:0] ACT_WR_STATE = 2'd0;
  localparam logic [1:0] ACT_WR_COV   = 2'd1;
  localparam logic [1:0] ACT_MEASURE  = 2'd2;
  localparam logic [1:0] ACT_READ     = 2'd3;

  localparam logic [1:0] CFG_ORIGIN = 2'd0;
  localparam logic [1:0] CFG_STDDEV = 2'd1;
  localparam logic [1:0] CFG_THRESH = 2'd2;

  localparam logic [1:0] EVT_NONE  = 2'd0;
  localparam logic [1:0] EVT_ENTER = 2'd1;
  localparam logic [1:0] EVT_CLEAR = 2'd2;

  localparam logic signed [31:0] ORIGIN_RST = 32'sd0;
  localparam logic [30:0] STDDEV_RST = 31'd65536;
  localparam logic [30:0] THRESH_RST = 31'd251658;
  localparam logic [30:0] BETA_MAX   = 31'h7fff_ffff;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         row;
    logic [3:0]         col;
    logic               read_matrix;
    logic signed [31:0] value;
    logic signed [31:0] baro_altitude;
  } in_t;

  typedef struct packed {
    logic signed [31:0] residual;
    logic [30:0]        beta;
    logic               fault;
    logic [1:0]         fault_event;
    logic signed [31:0] read_value;
  } out_t;

endpackage

### sv/baro_kalman_scalar_update_core.sv
// ----------------------------------------------------------------------------
// baro_kalman_scalar_update_core
// Scalar Kalman measurement update on a Q16.16 state vector and covariance.
// ----------------------------------------------------------------------------
// A measurement runs on the shared multiplier and the 2-bit-per-cycle divider,
// used once per updated element. One request is in flight at a time; a finished
// result waits in the output register. After reset a clearing pass zeroes the
// memories before any request.
module baro_kalman_scalar_update_core #(
  parameter int STATE_SIZE = bksu_pkg::STATE_SIZE_DEF,
  parameter int Z_POSITION = bksu_pkg::Z_POSITION_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bksu_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output bksu_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  localparam int ZI = Z_POSITION % STATE_SIZE;
  localparam int IW = $clog2(STATE_SIZE);
  localparam int AW = $clog2(STATE_SIZE * STATE_SIZE);

  typedef enum logic [15:0] {
    S_CLEAR = 16'h0001,
    S_IDLE  = 16'h0002,
    S_ACT   = 16'h0004,
    S_RDW   = 16'h0008,
    S_MRES  = 16'h0010,
    S_MS    = 16'h0020,
    S_SNRD  = 16'h0040,
    S_SNWR  = 16'h0080,
    S_BMUL  = 16'h0100,
    S_DINIT = 16'h0200,
    S_DIV   = 16'h0400,
    S_GATE  = 16'h0800,
    S_URD   = 16'h1000,
    S_UMUL  = 16'h2000,
    S_UWB   = 16'h4000,
    S_DONE  = 16'h8000
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] res;
    if (v > 37'sh0_7fff_ffff) res = 32'sh7fff_ffff;
    else if (v < -37'sh0_8000_0000) res = -32'sh7fff_ffff - 32'sd1;
    else res = v[31:0];
    return res;
  endfunction

  state_t state;
  bksu_pkg::in_t req;
  logic signed [31:0] origin;
  logic [30:0] stddev, thresh;
  logic fault_flag;

  logic signed [31:0] cov_mem [STATE_SIZE*STATE_SIZE];
  logic signed [31:0] x_mem [STATE_SIZE];
  logic signed [31:0] cov_q, x_q;
  logic cov_we, x_we;
  logic [AW-1:0] cov_wa, cov_ra, clr;
  logic [IW-1:0] x_wa, x_ra;
  logic signed [31:0] cov_wd, x_wd;

  logic signed [31:0] colz [STATE_SIZE];
  logic signed [31:0] rowz [STATE_SIZE];
  logic [IW-1:0] i, j;
  logic xph, snap_sel, upd;

  logic signed [31:0] pzz, r, old, rv;
  logic signed [47:0] s;
  logic signed [63:0] prod;
  logic signed [32:0] mul_a, mul_b;
  logic [48:0] rem;
  logic [33:0] num, quo;
  logic [4:0] dcnt;
  logic ovf, nsign;
  logic [30:0] beta_r;
  logic [1:0] evt;

  logic s_pos;
  logic [48:0] s_u, d1, r1, d2, r2;
  logic q1, q2;
  logic [63:0] nm;
  logic [30:0] betav;
  logic [34:0] qm;
  logic signed [35:0] sq;
  logic signed [31:0] y, newv;
  logic in_row, in_col;

  assign in_stall = (state != S_IDLE);
  assign s_pos = (s > 48'sd0);
  assign s_u = {1'b0, s};
  assign nm = prod[63] ? 64'(-prod) : 64'(prod);
  assign qm = ovf ? 35'h4_0000_0000 : {1'b0, quo};
  assign sq = nsign ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
  assign newv = sat32(37'(old) - 37'(sq));
  assign y = sat32(37'(req.baro_altitude) - 37'(origin));
  assign in_row = int'(req.row) < STATE_SIZE;
  assign in_col = int'(req.col) < STATE_SIZE;

  always_comb begin
    d1 = {rem[47:0], num[33]};
    q1 = d1 >= s_u;
    r1 = q1 ? d1 - s_u : d1;
    d2 = {r1[47:0], num[32]};
    q2 = d2 >= s_u;
    r2 = q2 ? d2 - s_u : d2;
  end

  always_comb begin
    if (!s_pos || ovf || quo > 34'(bksu_pkg::BETA_MAX)) betav = bksu_pkg::BETA_MAX;
    else betav = quo[30:0];
  end

  always_comb begin
    case (state)
      S_MRES:  begin mul_a = 33'(signed'({2'b00, stddev})); mul_b = mul_a; end
      S_BMUL:  begin mul_a = 33'(r); mul_b = 33'(r); end
      default: begin mul_a = 33'(colz[i]); mul_b = xph ? 33'(r) : 33'(rowz[j]); end
    endcase
  end

  always_comb begin
    cov_ra = AW'(ZI * STATE_SIZE + ZI);
    x_ra = IW'(ZI);
    case (state)
      S_ACT: begin
        if (req.action != bksu_pkg::ACT_MEASURE) begin
          cov_ra = AW'(int'(req.row) * STATE_SIZE + int'(req.col));
          x_ra = IW'(req.row);
        end
      end
      S_SNRD: cov_ra = snap_sel ? AW'(ZI * STATE_SIZE + int'(i))
                                : AW'(int'(i) * STATE_SIZE + ZI);
      S_URD: begin
        cov_ra = AW'(int'(i) * STATE_SIZE + int'(j));
        x_ra = i;
      end
      default: ;
    endcase
  end

  always_comb begin
    cov_we = 1'b0;
    cov_wa = AW'(int'(i) * STATE_SIZE + int'(j));
    cov_wd = newv;
    x_we = 1'b0;
    x_wa = i;
    x_wd = newv;
    case (state)
      S_CLEAR: begin
        cov_we = 1'b1;
        cov_wa = clr;
        cov_wd = 32'sd0;
        x_we = int'(clr) < STATE_SIZE;
        x_wa = clr[IW-1:0];
        x_wd = 32'sd0;
      end
      S_ACT: begin
        cov_wa = AW'(int'(req.row) * STATE_SIZE + int'(req.col));
        cov_wd = req.value;
        x_wa = IW'(req.row);
        x_wd = req.value;
        cov_we = (req.action == bksu_pkg::ACT_WR_COV) && in_row && in_col;
        x_we = (req.action == bksu_pkg::ACT_WR_STATE) && in_row;
      end
      S_UWB: begin
        cov_we = !xph;
        x_we = xph;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cov_we) cov_mem[cov_wa] <= cov_wd;
    cov_q <= cov_mem[cov_ra];
    if (x_we) x_mem[x_wa] <= x_wd;
    x_q <= x_mem[x_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= bksu_pkg::ORIGIN_RST;
      stddev <= bksu_pkg::STDDEV_RST;
      thresh <= bksu_pkg::THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bksu_pkg::CFG_ORIGIN: origin <= cfg_data;
        bksu_pkg::CFG_STDDEV: stddev <= cfg_data[30:0];
        bksu_pkg::CFG_THRESH: thresh <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      fault_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(STATE_SIZE * STATE_SIZE - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            r <= 32'sd0;
            beta_r <= '0;
            evt <= bksu_pkg::EVT_NONE;
            rv <= 32'sd0;
            state <= S_ACT;
          end
        end
        S_ACT: begin
          case (req.action)
            bksu_pkg::ACT_MEASURE: state <= S_MRES;
            bksu_pkg::ACT_READ:    state <= S_RDW;
            default:               state <= S_DONE;
          endcase
        end
        S_RDW: begin
          if (req.read_matrix) rv <= (in_row && in_col) ? cov_q : 32'sd0;
          else rv <= in_row ? x_q : 32'sd0;
          state <= S_DONE;
        end
        S_MRES: begin
          prod <= mul_a * mul_b;
          r <= sat32(37'(y) + 37'(x_q));
          pzz <= cov_q;
          state <= S_MS;
        end
        S_MS: begin
          s <= 48'(pzz) + 48'((prod + 64'sd32768) >>> 16);
          i <= '0;
          snap_sel <= 1'b0;
          state <= S_SNRD;
        end
        S_SNRD: state <= S_SNWR;
        S_SNWR: begin
          if (snap_sel) rowz[i] <= cov_q;
          else colz[i] <= cov_q;
          state <= S_SNRD;
          if (int'(i) == STATE_SIZE - 1) begin
            i <= '0;
            snap_sel <= 1'b1;
            if (snap_sel) state <= s_pos ? S_BMUL : S_GATE;
          end else begin
            i <= i + IW'(1);
          end
        end
        S_BMUL: begin
          prod <= mul_a * mul_b;
          upd <= 1'b0;
          state <= S_DINIT;
        end
        S_DINIT: begin
          nsign <= prod[63];
          rem <= {20'd0, nm[62:34]};
          ovf <= {20'd0, nm[62:34]} >= s_u;
          num <= nm[33:0];
          quo <= '0;
          dcnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= r2;
          num <= {num[31:0], 2'b00};
          quo <= {quo[31:0], q1, q2};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd16) state <= upd ? S_UWB : S_GATE;
        end
        S_GATE: begin
          beta_r <= betav;
          if (betav > thresh) begin
            if (!fault_flag) begin
              fault_flag <= 1'b1;
              evt <= bksu_pkg::EVT_ENTER;
            end
          end else if (fault_flag) begin
            fault_flag <= 1'b0;
            evt <= bksu_pkg::EVT_CLEAR;
          end
          i <= '0;
          j <= '0;
          xph <= 1'b1;
          state <= s_pos ? S_URD : S_DONE;
        end
        S_URD: state <= S_UMUL;
        S_UMUL: begin
          prod <= mul_a * mul_b;
          old <= xph ? x_q : cov_q;
          upd <= 1'b1;
          state <= S_DINIT;
        end
        S_UWB: begin
          state <= S_URD;
          if (xph) begin
            xph <= 1'b0;
            j <= '0;
          end else if (int'(j) == STATE_SIZE - 1) begin
            if (int'(i) == STATE_SIZE - 1) state <= S_DONE;
            else begin
              i <= i + IW'(1);
              xph <= 1'b1;
            end
          end else begin
            j <= j + IW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data.residual <= r;
            out_data.beta <= beta_r;
            out_data.fault <= fault_flag;
            out_data.fault_event <= evt;
            out_data.read_value <= rv;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the barometric Kalman scalar update core. A scoreboard keeps
// its own copy of the state vector, covariance and fault flag, predicts the
// result of every accepted request and checks the results in order. Stimulus
// is a directed part followed by random write / measure / read sequences,
// with random idling on both channels and several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N  = bksu_pkg::STATE_SIZE_DEF;
  localparam int ZI = bksu_pkg::Z_POSITION_DEF % bksu_pkg::STATE_SIZE_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  class kalman_scoreboard;
    int              xv[N];
    int              pm[N*N];
    bit              flt;
    int              origin;
    logic [30:0]     stddev;
    logic [30:0]     thresh;
    bksu_pkg::out_t  pending_q[$];
    int              mismatches;

    function new();
      foreach (xv[i]) xv[i] = 0;
      foreach (pm[i]) pm[i] = 0;
      flt = 0;
      origin = bksu_pkg::ORIGIN_RST;
      stddev = bksu_pkg::STDDEV_RST;
      thresh = bksu_pkg::THRESH_RST;
      mismatches = 0;
    endfunction

    function int sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
    endfunction

    function void configure(logic [1:0] idx, logic [31:0] d);
      case (idx)
        bksu_pkg::CFG_ORIGIN: origin = d;
        bksu_pkg::CFG_STDDEV: stddev = d[30:0];
        bksu_pkg::CFG_THRESH: thresh = d[30:0];
        default: ;
      endcase
    endfunction

    function void measure(int baro, ref bksu_pkg::out_t o);
      longint y, rn, s, bt, q;
      logic [63:0] sq;
      int r;
      int colz[N];
      int rowz[N];
      y = sat32(longint'(baro) - longint'(origin));
      sq = 64'(stddev) * 64'(stddev) + 64'd32768;
      rn = longint'(sq >> 16);
      s = longint'(pm[ZI*N+ZI]) + rn;
      r = sat32(y + longint'(xv[ZI]));
      if (s > 0) begin
        q = (longint'(r) * longint'(r)) / s;
        bt = (q > 64'sd2147483647) ? 64'sd2147483647 : q;
      end else begin
        bt = 64'sd2147483647;
      end
      o.fault_event = bksu_pkg::EVT_NONE;
      if (bt > longint'(thresh)) begin
        if (!flt) begin
          flt = 1;
          o.fault_event = bksu_pkg::EVT_ENTER;
        end
      end else if (flt) begin
        flt = 0;
        o.fault_event = bksu_pkg::EVT_CLEAR;
      end
      if (s > 0) begin
        for (int i = 0; i < N; i++) begin
          colz[i] = pm[i*N+ZI];
          rowz[i] = pm[ZI*N+i];
        end
        for (int i = 0; i < N; i++) begin
          xv[i] = sat32(longint'(xv[i]) - (longint'(colz[i]) * longint'(r)) / s);
          for (int j = 0; j < N; j++)
            pm[i*N+j] = sat32(longint'(pm[i*N+j]) -
                              (longint'(colz[i]) * longint'(rowz[j])) / s);
        end
      end
      o.residual = r;
      o.beta = bt[30:0];
    endfunction

    function void note(bksu_pkg::in_t it);
      bksu_pkg::out_t o;
      o = '0;
      case (it.action)
        bksu_pkg::ACT_WR_STATE: if (it.row < N) xv[it.row] = it.value;
        bksu_pkg::ACT_WR_COV:
          if (it.row < N && it.col < N) pm[it.row*N+it.col] = it.value;
        bksu_pkg::ACT_MEASURE: measure(it.baro_altitude, o);
        default: begin
          if (!it.read_matrix) begin
            if (it.row < N) o.read_value = xv[it.row];
          end else if (it.row < N && it.col < N) begin
            o.read_value = pm[it.row*N+it.col];
          end
        end
      endcase
      o.fault = flt;
      pending_q.push_back(o);
    endfunction

    function void check(bksu_pkg::out_t got);
      bksu_pkg::out_t exp_o;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_o = pending_q.pop_front();
      if (got !== exp_o) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected res=%0d beta=%0d flt=%0d evt=%0d rd=%0d,",
                    " got res=%0d beta=%0d flt=%0d evt=%0d rd=%0d"},
                   exp_o.residual, exp_o.beta, exp_o.fault, exp_o.fault_event,
                   exp_o.read_value, got.residual, got.beta, got.fault,
                   got.fault_event, got.read_value);
      end
    endfunction
  endclass

  logic  clk = 0;
  logic  rst = 1;
  logic  in_valid = 0;
  logic  in_stall;
  bksu_pkg::in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 0;
  bksu_pkg::out_t  out_data;
  logic  cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  kalman_scoreboard sb = new();
  bit quiet = 0;
  bit hold_go = 0;
  bit hold_done = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;
  int sent = 0;

  baro_kalman_scalar_update_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      out_stall <= 1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 400) hold_done <= 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("baro_kalman_scalar_update_core test failed");
      $finish;
    end
  end

  function automatic bksu_pkg::in_t mk(logic [1:0] a, int r, int c, int m, int v, int b);
    bksu_pkg::in_t it;
    it.action = a;
    it.row = 4'(r);
    it.col = 4'(c);
    it.read_matrix = 1'(m);
    it.value = v;
    it.baro_altitude = b;
    return it;
  endfunction

  function automatic int rnd_val();
    if ($urandom_range(99) < 25) return $urandom;
    return $signed($urandom_range(2097152)) - 1048576;
  endfunction

  task automatic send_req(bksu_pkg::in_t it);
    if (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(it);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    sb.configure(idx, d);
  endtask

  task automatic random_seq();
    int k;
    if ($urandom_range(99) < 20) begin
      send_req(mk(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom));
      return;
    end
    k = $urandom_range(2, 6);
    repeat (k) begin
      case ($urandom_range(4))
        0: send_req(mk(bksu_pkg::ACT_WR_STATE, $urandom_range(N-1), $urandom, $urandom,
                       rnd_val(), $urandom));
        1: send_req(mk(bksu_pkg::ACT_WR_COV, ZI, ZI, $urandom,
                       $urandom_range(99) < 85 ? $urandom_range(1 << 20) : rnd_val(),
                       $urandom));
        2: send_req(mk(bksu_pkg::ACT_WR_COV, $urandom_range(N-1), ZI, $urandom,
                       rnd_val(), $urandom));
        3: send_req(mk(bksu_pkg::ACT_WR_COV, ZI, $urandom_range(N-1), $urandom,
                       rnd_val(), $urandom));
        default: send_req(mk(bksu_pkg::ACT_WR_COV, $urandom_range(N-1),
                             $urandom_range(N-1), $urandom, rnd_val(), $urandom));
      endcase
    end
    if ($urandom_range(99) < 85)
      send_req(mk(bksu_pkg::ACT_MEASURE, $urandom, $urandom, $urandom, $urandom,
                  rnd_val()));
    repeat ($urandom_range(1, 3))
      send_req(mk(bksu_pkg::ACT_READ,
                  $urandom_range(99) < 90 ? $urandom_range(N-1) : $urandom,
                  $urandom_range(99) < 90 ? $urandom_range(N-1) : $urandom,
                  $urandom, $urandom, $urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_reg(bksu_pkg::CFG_ORIGIN, 32'h0001_0000);
    write_reg(bksu_pkg::CFG_STDDEV, 32'h8001_0000);
    write_reg(bksu_pkg::CFG_THRESH, 32'd251658);

    send_req(mk(bksu_pkg::ACT_WR_STATE, 0, 0, 0, 32'h7fff_ffff, 0));
    send_req(mk(bksu_pkg::ACT_WR_STATE, N-1, 0, 0, 32'h8000_0000, 0));
    send_req(mk(bksu_pkg::ACT_WR_STATE, 15, 0, 0, 32'h1234_5678, 0));
    send_req(mk(bksu_pkg::ACT_WR_COV, ZI, ZI, 0, 32'h0002_0000, 0));
    send_req(mk(bksu_pkg::ACT_WR_COV, 0, ZI, 0, 32'h7fff_ffff, 0));
    send_req(mk(bksu_pkg::ACT_WR_COV, ZI, N-1, 0, 32'h8000_0000, 0));
    send_req(mk(bksu_pkg::ACT_WR_COV, N-1, 15, 0, 32'h5555_5555, 0));
    send_req(mk(bksu_pkg::ACT_WR_COV, 15, 0, 0, 32'h5555_5555, 0));
    send_req(mk(bksu_pkg::ACT_MEASURE, 0, 0, 0, 0, 32'h0003_0000));
    send_req(mk(bksu_pkg::ACT_MEASURE, 0, 0, 0, 0, 32'h7fff_ffff));
    send_req(mk(bksu_pkg::ACT_MEASURE, 0, 0, 0, 0, 32'h8000_0000));
    send_req(mk(bksu_pkg::ACT_READ, 0, 0, 0, 0, 0));
    send_req(mk(bksu_pkg::ACT_READ, N-1, 0, 0, 0, 0));
    send_req(mk(bksu_pkg::ACT_READ, 15, 0, 0, 0, 0));
    send_req(mk(bksu_pkg::ACT_READ, ZI, ZI, 1, 0, 0));
    send_req(mk(bksu_pkg::ACT_READ, 15, 15, 1, 0, 0));
    send_req(mk(bksu_pkg::ACT_READ, 0, N, 1, 0, 0));
    send_req(mk(bksu_pkg::ACT_WR_COV, ZI, ZI, 0, 32'hfff0_0000, 0));
    drain();

    write_reg(bksu_pkg::CFG_STDDEV, 32'd0);
    write_reg(bksu_pkg::CFG_ORIGIN, 32'h8000_0000);
    write_reg(bksu_pkg::CFG_THRESH, 32'd0);
    send_req(mk(bksu_pkg::ACT_MEASURE, 0, 0, 0, 0, 32'h0001_0000));
    send_req(mk(bksu_pkg::ACT_READ, ZI, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(bksu_pkg::CFG_ORIGIN, 0);
                 write_reg(bksu_pkg::CFG_STDDEV, 32'h0001_0000);
                 write_reg(bksu_pkg::CFG_THRESH, 32'd251658); end
        1: begin write_reg(bksu_pkg::CFG_ORIGIN, 32'h7fff_ffff);
                 write_reg(bksu_pkg::CFG_STDDEV, 32'h7fff_ffff);
                 write_reg(bksu_pkg::CFG_THRESH, 32'h7fff_ffff); end
        2: begin write_reg(bksu_pkg::CFG_ORIGIN, $urandom_range(1 << 22) - (1 << 21));
                 write_reg(bksu_pkg::CFG_STDDEV, $urandom_range(1 << 18));
                 write_reg(bksu_pkg::CFG_THRESH, $urandom_range(1 << 20)); end
        3: begin write_reg(bksu_pkg::CFG_ORIGIN, $urandom);
                 write_reg(bksu_pkg::CFG_STDDEV, $urandom);
                 write_reg(bksu_pkg::CFG_THRESH, $urandom); end
        4: begin write_reg(bksu_pkg::CFG_ORIGIN, 0); write_reg(bksu_pkg::CFG_STDDEV, 0);
                 write_reg(bksu_pkg::CFG_THRESH, 32'd65536); end
        default: begin write_reg(bksu_pkg::CFG_ORIGIN, 32'hfff0_0000);
                 write_reg(bksu_pkg::CFG_STDDEV, 32'd32768);
                 write_reg(bksu_pkg::CFG_THRESH, 32'd251658); end
      endcase
      quiet = (ph == 2);
      if (ph == 3) hold_go = 1;
      while (sb.pending_q.size() < 1000 && sent < (ph + 1) * 190)
        random_seq();
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("baro_kalman_scalar_update_core test passed");
    else
      $display("baro_kalman_scalar_update_core test failed");
    $finish;
  end
endmodule

### baro_kalman_scalar_update_core.f
sv/bksu_pkg.sv
sv/baro_kalman_scalar_update_core.sv
dv/tb_top.sv
